@@ sv/mfb_pkg.sv @@
package mfb_pkg;

    // Item opcodes
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    // Register indexes on the config port
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ROTATION = 3'd2;
    localparam logic [2:0] CFG_MODE     = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_PAGES    = 3'd5;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Write mode codes
    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_TRANSP = 2'd1;
    localparam logic [1:0] MODE_INVERT = 2'd2;
    localparam logic [1:0] MODE_UNDEF  = 2'd3;

    // Command classes handed from the front end to the executor
    typedef enum logic [1:0] {
        K_DONE,   // no store access, result is ready at once
        K_WRITE,  // read-modify-write of one byte
        K_READ,   // read one byte
        K_CLEAR   // sweep the whole store to zero
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  mask;    // bit to touch inside the byte
        logic        lit;     // 1 sets the bit, 0 clears it
        logic        status;  // status of an immediate result
    } t_cmd_ctl;

    typedef struct packed {
        logic [7:0]  data;
        logic        status;
    } t_res;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

endpackage

@@ sv/mfb_fifo.sv @@
module mfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ sv/mfb_front.sv @@
module mfb_front #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_PAGES = 8,
    parameter int ADDR_W    = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_source_col,
    input  logic [7:0]           i_source_row,
    input  logic                 i_pixel_bit,
    input  logic [2:0]           i_read_page,
    input  logic [6:0]           i_read_column,
    output mfb_pkg::t_cmd_ctl    o_cmd,
    output logic [ADDR_W-1:0]    o_addr
);

    localparam int IDX_W = 14;

    logic [7:0] r_origin_x, r_origin_y, r_width;
    logic [1:0] r_rotation, r_mode;
    logic [3:0] r_pages;

    logic [7:0]       eff_w;
    logic [3:0]       eff_p;
    logic [7:0]       dx, dy;
    logic             do_write, lit, draw_off, read_off;
    logic [4:0]       mul_page;
    logic [7:0]       mul_col;
    logic [IDX_W-1:0] idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_rotation <= '0;
            r_mode     <= '0;
            r_width    <= 8'd128;
            r_pages    <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfb_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                mfb_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                mfb_pkg::CFG_ROTATION: r_rotation <= i_cfg_data[1:0];
                mfb_pkg::CFG_MODE:     r_mode     <= i_cfg_data[1:0];
                mfb_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                mfb_pkg::CFG_PAGES:    r_pages    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // size in use, clamped to the store
    assign eff_w = ({1'b0, r_width} < 9'(MAX_WIDTH)) ? r_width : 8'(MAX_WIDTH);
    assign eff_p = ({2'b0, r_pages} < 6'(MAX_PAGES)) ? r_pages : 4'(MAX_PAGES);

    always_comb begin
        unique case (r_rotation)
            mfb_pkg::ROT_0: begin
                dx = r_origin_x + i_source_col;
                dy = r_origin_y + i_source_row;
            end
            mfb_pkg::ROT_90: begin
                dx = r_origin_x - i_source_row;
                dy = r_origin_y + i_source_col;
            end
            mfb_pkg::ROT_180: begin
                dx = r_origin_x - i_source_col;
                dy = r_origin_y - i_source_row;
            end
            default: begin
                dx = r_origin_x + i_source_row;
                dy = r_origin_y - i_source_col;
            end
        endcase
    end

    always_comb begin
        unique case (r_mode)
            mfb_pkg::MODE_COPY: begin
                do_write = 1'b1;
                lit      = i_pixel_bit;
            end
            mfb_pkg::MODE_TRANSP: begin
                do_write = i_pixel_bit;
                lit      = 1'b1;
            end
            mfb_pkg::MODE_INVERT: begin
                do_write = 1'b1;
                lit      = !i_pixel_bit;
            end
            default: begin
                do_write = 1'b0;
                lit      = 1'b0;
            end
        endcase
    end

    assign draw_off = (dx >= eff_w) || (dy[7:3] >= {1'b0, eff_p});
    assign read_off = ({1'b0, i_read_column} >= eff_w) || ({1'b0, i_read_page} >= eff_p);

    // one multiplier serves both draw and read addressing
    assign mul_page = (i_opcode == mfb_pkg::OP_READ) ? {2'b0, i_read_page} : dy[7:3];
    assign mul_col  = (i_opcode == mfb_pkg::OP_READ) ? {1'b0, i_read_column} : dx;
    assign idx      = IDX_W'(mul_page) * IDX_W'(eff_w) + IDX_W'(mul_col);
    assign o_addr   = ADDR_W'(idx);

    always_comb begin
        o_cmd.kind   = mfb_pkg::K_DONE;
        o_cmd.mask   = 8'd1 << dy[2:0];
        o_cmd.lit    = lit;
        o_cmd.status = 1'b0;
        unique case (i_opcode)
            mfb_pkg::OP_DRAW: begin
                if (do_write && draw_off) begin
                    o_cmd.status = 1'b1;
                end else if (do_write) begin
                    o_cmd.kind = mfb_pkg::K_WRITE;
                end
            end
            mfb_pkg::OP_CLEAR: o_cmd.kind = mfb_pkg::K_CLEAR;
            mfb_pkg::OP_READ: begin
                if (read_off) begin
                    o_cmd.status = 1'b1;
                end else begin
                    o_cmd.kind = mfb_pkg::K_READ;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ sv/mfb_back.sv @@
module mfb_back #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mfb_pkg::t_cmd_ctl i_cmd,
    input  logic [ADDR_W-1:0] i_cmd_addr,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output mfb_pkg::t_res     o_res,
    output logic              o_init_busy
);

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_RMW, S_RD, S_CLR} t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]        r_mask, n_mask;
    logic              r_lit, n_lit;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rdata;
    logic              rd_en, wr_en, last;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    assign last        = (r_cnt == ADDR_W'(DEPTH - 1));
    assign o_init_busy = (r_state == S_INIT);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        n_mask     = r_mask;
        n_lit      = r_lit;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        waddr      = r_cnt;
        wdata      = '0;
        unique case (r_state)
            S_INIT: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // one result slot is reserved before a command starts
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_addr    = i_cmd_addr;
                    n_mask    = i_cmd.mask;
                    n_lit     = i_cmd.lit;
                    unique case (i_cmd.kind)
                        mfb_pkg::K_DONE: begin
                            o_res_push   = 1'b1;
                            o_res.status = i_cmd.status;
                        end
                        mfb_pkg::K_WRITE: begin
                            rd_en   = 1'b1;
                            n_state = S_RMW;
                        end
                        mfb_pkg::K_READ: begin
                            rd_en   = 1'b1;
                            n_state = S_RD;
                        end
                        default: begin
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                    endcase
                end
            end
            S_RMW: begin
                wr_en      = 1'b1;
                waddr      = r_addr;
                wdata      = r_lit ? (r_rdata | r_mask) : (r_rdata & ~r_mask);
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            S_RD: begin
                o_res_push = 1'b1;
                o_res.data = r_rdata;
                n_state    = S_IDLE;
            end
            default: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_addr <= n_addr;
        r_mask <= n_mask;
        r_lit  <= n_lit;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[i_cmd_addr];
        end
    end

    // write-back lands on the byte fetched the cycle before
    a_rmw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> ($past(rd_en) && r_addr == $past(i_cmd_addr)))
        else $error("rmw write address differs from fetch address");

    // a set status only comes from an immediate result
    a_status_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.status) |-> (r_state == S_IDLE && o_cmd_pop))
        else $error("status set on a store access result");

endmodule

@@ sv/mono_framebuffer_blit.sv @@
// Flow: an accepted item enters the command queue; the executor takes it while idle and a
// result slot is free. Items without a store access (off screen, dropped, undefined) push
// their result at once; draw items fetch the byte, then write it back through the single
// store port, and reads fetch the byte, then push it. A clear sweeps the store, one byte per
// cycle, and holds the executor until done. Reset: synchronous, active low; afterwards full
// stays high while the store is swept to zero. Config writes are taken throughout.
module mono_framebuffer_blit #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_PAGES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // input queue side
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_source_col,
    input  logic [7:0] i_source_row,
    input  logic       i_pixel_bit,
    input  logic [2:0] i_read_page,
    input  logic [6:0] i_read_column,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_read_data,
    output logic       o_status
);

    localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMD_W  = $bits(mfb_pkg::t_cmd_ctl) + ADDR_W;
    localparam int RES_W  = $bits(mfb_pkg::t_res);

    // front end: config registers, rotation and clipping, address compute
    mfb_pkg::t_cmd_ctl front_cmd, q_cmd;
    logic [ADDR_W-1:0] front_addr, q_addr;
    logic [CMD_W-1:0]  cmdq_wdata, cmdq_rdata;
    logic              cmdq_full, cmdq_empty, cmd_pop, init_busy, in_xfer;

    // back end to result queue
    mfb_pkg::t_res     res, res_q;
    logic              res_push, resq_full;
    logic [RES_W-1:0]  resq_rdata;

    // no items while the post-reset sweep runs
    assign full    = cmdq_full || init_busy;
    assign in_xfer = push && !full;

    mfb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_PAGES (MAX_PAGES),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_source_col  (i_source_col),
        .i_source_row  (i_source_row),
        .i_pixel_bit   (i_pixel_bit),
        .i_read_page   (i_read_page),
        .i_read_column (i_read_column),
        .o_cmd         (front_cmd),
        .o_addr        (front_addr)
    );

    // short command queue decouples classification from execution
    assign cmdq_wdata      = {front_cmd, front_addr};
    assign {q_cmd, q_addr} = cmdq_rdata;

    mfb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (mfb_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (cmdq_wdata),
        .i_pop   (cmd_pop),
        .o_data  (cmdq_rdata),
        .o_full  (cmdq_full),
        .o_empty (cmdq_empty)
    );

    mfb_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmdq_empty),
        .i_cmd       (q_cmd),
        .i_cmd_addr  (q_addr),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (resq_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_init_busy (init_busy)
    );

    // result queue doubles as output register; the back end keeps going
    // while a finished result waits for its transfer
    mfb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (mfb_pkg::RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (resq_rdata),
        .o_full  (resq_full),
        .o_empty (empty)
    );

    assign res_q       = resq_rdata;
    assign o_read_data = res_q.data;
    assign o_status    = res_q.status;

    // store sweep blocks input right after reset
    a_init_full: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input open during store sweep");

    // the reserved result slot is always there
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !resq_full)
        else $error("result queue overflow");

    // a command is only started with the executor past its sweep
    a_pop_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (!init_busy && !cmdq_empty))
        else $error("command taken during sweep or from empty queue");

endmodule
